// ----- sv/alle_pkg.sv -----
// Package with the types, constants and helper functions of the linked list engine.
package alle_pkg;

  localparam int ENTRIES     = 16;
  localparam int VALUE_BITS  = 32;
  localparam int MAX_RESULTS = 16;
  localparam int WORD_BITS   = 32;

  localparam int IDX_W       = $clog2(ENTRIES + 1);
  localparam int ADDR_W      = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int WALK_LIMIT  = (MAX_RESULTS < ENTRIES) ? MAX_RESULTS : ENTRIES;
  localparam int CNT_W       = (WALK_LIMIT > 1) ? $clog2(WALK_LIMIT) : 1;
  localparam int QUEUE_DEPTH = 2;

  typedef enum logic [1:0] {
    OP_PUSH_FRONT = 2'd0,
    OP_POP_FRONT  = 2'd1,
    OP_PUSH_BACK  = 2'd2,
    OP_TRAVERSE   = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_LOOKUP,
    S_LINK_TAIL,
    S_WALK
  } state_t;

  typedef struct packed {
    op_t                   op;
    logic                  is_push;
    logic [VALUE_BITS-1:0] value;
  } cmd_t;

  function automatic logic [VALUE_BITS-1:0] fit_value(input logic signed [WORD_BITS-1:0] raw);
    return VALUE_BITS'(raw);
  endfunction

  function automatic logic [WORD_BITS-1:0] word_value(input logic [VALUE_BITS-1:0] v);
    logic signed [VALUE_BITS-1:0] s;
    s = v;
    return WORD_BITS'(s);
  endfunction

endpackage

// ----- sv/alle_if.sv -----
// Valid/ready channel interfaces for the input words and the result words.
interface alle_in_if import alle_pkg::*; (input logic clk);
  logic                        valid;
  logic                        ready;
  logic [1:0]                  opcode;
  logic signed [WORD_BITS-1:0] value_in;

  modport source (output valid, opcode, value_in, input ready);
  modport sink (input valid, opcode, value_in, output ready);
endinterface

interface alle_out_if import alle_pkg::*; (input logic clk);
  logic                        valid;
  logic                        ready;
  logic signed [WORD_BITS-1:0] value_out;
  logic                        has_value;
  logic                        last;
  logic [1:0]                  status;
  logic                        is_empty;
  logic                        is_full;

  modport source (output valid, value_out, has_value, last, status, is_empty, is_full,
                  input ready);
  modport sink (input valid, value_out, has_value, last, status, is_empty, is_full,
                output ready);
endinterface

// ----- sv/alle_front.sv -----
// Front end: accepts input words, decodes them into commands and queues them.
module alle_front import alle_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  alle_in_if.sink    item,
  output cmd_t       cmd,
  output logic       cmd_valid,
  input  logic       cmd_take
);

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_BITS = $clog2(QUEUE_DEPTH + 1);

  cmd_t                slots [QUEUE_DEPTH];
  logic [PTR_W-1:0]    wr_ptr;
  logic [PTR_W-1:0]    rd_ptr;
  logic [CNT_BITS-1:0] count;
  cmd_t                decoded;
  logic                push;
  logic                pop;

  always_comb begin
    decoded.op      = op_t'(item.opcode);
    decoded.is_push = (decoded.op == OP_PUSH_FRONT) || (decoded.op == OP_PUSH_BACK);
    decoded.value   = fit_value(item.value_in);
  end

  assign item.ready = (count != CNT_BITS'(QUEUE_DEPTH));
  assign push       = item.valid && item.ready;
  assign cmd_valid  = (count != '0);
  assign pop        = cmd_valid && cmd_take;
  assign cmd        = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= decoded;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + CNT_BITS'(1);
      end else if (pop && !push) begin
        count <= count - CNT_BITS'(1);
      end
    end
  end

endmodule

// ----- sv/alle_back.sv -----
// Back end: executes list commands on the link and value memories and registers results.
module alle_back import alle_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  cmd_t       cmd,
  input  logic       cmd_valid,
  output logic       cmd_take,
  alle_out_if.source result
);

  state_t                state, state_next;
  logic [IDX_W-1:0]      head, head_next;
  logic [IDX_W-1:0]      tail, tail_next;
  logic [IDX_W-1:0]      free_head, free_next;
  logic [IDX_W-1:0]      addr, addr_next;
  logic [CNT_W-1:0]      cnt, cnt_next;
  cmd_t                  cur;

  logic [IDX_W-1:0]      link_mem [ENTRIES];
  logic [ENTRIES-1:0]    link_valid;
  logic [VALUE_BITS-1:0] val_mem [ENTRIES];
  logic [IDX_W-1:0]      link_q;
  logic [VALUE_BITS-1:0] val_q;

  logic [ADDR_W-1:0]     raddr;
  logic                  lwe;
  logic [ADDR_W-1:0]     lwaddr;
  logic [IDX_W-1:0]      lwdata;
  logic                  vwe;

  logic                  out_free;
  logic                  emit;
  logic [WORD_BITS-1:0]  e_value;
  logic                  e_has;
  logic                  e_last;
  status_t               e_status;
  logic                  e_empty;
  logic                  e_full;

  logic                  list_empty;
  logic                  store_full;
  logic                  link_end;
  logic                  walk_fin;

  assign out_free   = !result.valid || result.ready;
  assign list_empty = (head >= IDX_W'(ENTRIES));
  assign store_full = (free_head >= IDX_W'(ENTRIES));
  assign link_end   = (link_q >= IDX_W'(ENTRIES));
  assign walk_fin   = link_end || (cnt == CNT_W'(WALK_LIMIT - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      head      <= IDX_W'(ENTRIES);
      tail      <= IDX_W'(ENTRIES);
      free_head <= '0;
      addr      <= '0;
      cnt       <= '0;
    end else begin
      state     <= state_next;
      head      <= head_next;
      tail      <= tail_next;
      free_head <= free_next;
      addr      <= addr_next;
      cnt       <= cnt_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_take) begin
      cur <= cmd;
    end
  end

  always_comb begin
    state_next = state;
    head_next  = head;
    tail_next  = tail;
    free_next  = free_head;
    addr_next  = addr;
    cnt_next   = cnt;
    cmd_take   = 1'b0;
    raddr      = addr[ADDR_W-1:0];
    lwe        = 1'b0;
    lwaddr     = addr[ADDR_W-1:0];
    lwdata     = head;
    vwe        = 1'b0;
    emit       = 1'b0;
    e_value    = '0;
    e_has      = 1'b0;
    e_last     = 1'b1;
    e_status   = ST_DONE;
    e_empty    = list_empty;
    e_full     = store_full;

    unique case (state)
      S_IDLE: begin
        if (cmd_valid && out_free) begin
          cmd_take = 1'b1;
          if (cmd.is_push) begin
            if (store_full) begin
              emit     = 1'b1;
              e_status = ST_FULL;
            end else begin
              raddr      = free_head[ADDR_W-1:0];
              addr_next  = free_head;
              state_next = S_LOOKUP;
            end
          end else if (cmd.op == OP_POP_FRONT) begin
            if (list_empty) begin
              emit     = 1'b1;
              e_status = ST_EMPTY;
            end else begin
              raddr      = head[ADDR_W-1:0];
              addr_next  = head;
              state_next = S_LOOKUP;
            end
          end else begin
            if (list_empty) begin
              emit = 1'b1;
            end else begin
              raddr      = head[ADDR_W-1:0];
              addr_next  = head;
              cnt_next   = '0;
              state_next = S_WALK;
            end
          end
        end
      end
      S_LOOKUP: begin
        if (out_free) begin
          lwe = 1'b1;
          if (cur.op == OP_PUSH_FRONT) begin
            vwe        = 1'b1;
            free_next  = link_q;
            lwdata     = head;
            head_next  = addr;
            if (list_empty) begin
              tail_next = addr;
            end
            emit       = 1'b1;
            e_empty    = 1'b0;
            e_full     = link_end;
            state_next = S_IDLE;
          end else if (cur.op == OP_PUSH_BACK) begin
            vwe       = 1'b1;
            free_next = link_q;
            lwdata    = IDX_W'(ENTRIES);
            if (list_empty) begin
              head_next  = addr;
              tail_next  = addr;
              emit       = 1'b1;
              e_empty    = 1'b0;
              e_full     = link_end;
              state_next = S_IDLE;
            end else begin
              state_next = S_LINK_TAIL;
            end
          end else begin
            free_next = addr;
            lwdata    = free_head;
            head_next = link_q;
            if (link_end) begin
              tail_next = IDX_W'(ENTRIES);
            end
            emit       = 1'b1;
            e_empty    = link_end;
            e_full     = 1'b0;
            state_next = S_IDLE;
          end
        end
      end
      S_LINK_TAIL: begin
        if (out_free) begin
          if (tail < IDX_W'(ENTRIES)) begin
            lwe    = 1'b1;
            lwaddr = tail[ADDR_W-1:0];
            lwdata = addr;
          end
          tail_next  = addr;
          emit       = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_WALK: begin
        if (out_free) begin
          emit    = 1'b1;
          e_value = word_value(val_q);
          e_has   = 1'b1;
          e_last  = walk_fin;
          if (walk_fin) begin
            state_next = S_IDLE;
          end else begin
            addr_next = link_q;
            raddr     = link_q[ADDR_W-1:0];
            cnt_next  = cnt + CNT_W'(1);
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (lwe) begin
      link_mem[lwaddr] <= lwdata;
    end
    if (vwe) begin
      val_mem[addr[ADDR_W-1:0]] <= cur.value;
    end
    link_q <= link_valid[raddr] ? link_mem[raddr] : IDX_W'(raddr) + IDX_W'(1);
    val_q  <= val_mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      link_valid <= '0;
    end else if (lwe) begin
      link_valid[lwaddr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (emit) begin
      result.valid <= 1'b1;
    end else if (result.ready) begin
      result.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      result.value_out <= e_value;
      result.has_value <= e_has;
      result.last      <= e_last;
      result.status    <= e_status;
      result.is_empty  <= e_empty;
      result.is_full   <= e_full;
    end
  end

endmodule

// ----- sv/array_linked_list_engine_unit.sv -----
// Top level of the array-based linked list engine with a free list.
// A singly linked list lives in a fixed store of ENTRIES nodes; free nodes are chained
// through the same link memory. Each input word pushes at the front, pops the front,
// appends at the back or walks the list; every operation reports done, full or empty
// together with the list's empty and full flags. Input words go into a two-word command
// queue, so the port keeps taking words while the engine works or a result waits, until
// the queue is full. The link memory has one write port and a registered read port: push
// front and pop pass through S_IDLE and S_LOOKUP, an append to a non-empty list also
// through S_LINK_TAIL, and a traverse emits one node per S_WALK step (at most WALK_LIMIT
// nodes). A rejected push and a pop or traverse of an empty list are answered in S_IDLE.
// After reset the link memory reads as a free chain of all nodes, with no clearing pass.
module array_linked_list_engine_unit import alle_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  alle_in_if.sink    item,
  alle_out_if.source result
);

  cmd_t cmd;
  logic cmd_valid;
  logic cmd_take;

  alle_front u_front (
    .clk       (clk),
    .rst       (rst),
    .item      (item),
    .cmd       (cmd),
    .cmd_valid (cmd_valid),
    .cmd_take  (cmd_take)
  );

  alle_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .cmd_valid (cmd_valid),
    .cmd_take  (cmd_take),
    .result    (result)
  );

endmodule
